@@ hw/rtl/fptw_pkg.sv @@
// fptw_pkg: constants, codes and helpers for the four-level page table walker
// no dependencies; used by the channel interfaces and the walker core

package fptw_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned VADDR_W = 48;
    localparam int unsigned PADDR_W = 4;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [VADDR_W-1:0] t_vaddr;
    typedef logic [1:0]         t_kind;
    typedef logic [2:0]         t_level;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RESP  = 1'b1;

    localparam t_kind KIND_READ  = 2'd0;
    localparam t_kind KIND_DONE  = 2'd1;
    localparam t_kind KIND_FAULT = 2'd2;

    localparam t_level LVL_IDLE = 3'd0;
    localparam t_level LVL_PT   = 3'd1;
    localparam t_level LVL_PD   = 3'd2;
    localparam t_level LVL_PDPT = 3'd3;
    localparam t_level LVL_PML4 = 3'd4;

    localparam logic [PADDR_W-1:0] REG_KIMG_BASE = 4'h0;
    localparam logic [PADDR_W-1:0] REG_DMAP_BASE = 4'h8;

    localparam t_addr ENTRY_FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam t_addr KIMG_WINDOW_BASE = 64'hFFFF_FFFF_8000_0000;
    localparam t_addr KIMG_PHYS_RST    = 64'h0000_0000_04A0_0000;
    localparam t_addr DMAP_VIRT_RST    = 64'hFFFF_8880_0000_0000;

    localparam int unsigned WIN_LO_W = 31;
    localparam int unsigned OFF_W    = 12;

    // 9-bit table index of the given level, scaled to a byte offset
    function automatic t_addr index_bytes(input t_vaddr va, input t_level lvl);
        logic [8:0] idx;
        begin
            case (lvl)
                LVL_PML4: idx = va[47:39];
                LVL_PDPT: idx = va[38:30];
                LVL_PD:   idx = va[29:21];
                LVL_PT:   idx = va[20:12];
                default:  idx = va[20:12];
            endcase
            index_bytes = {52'd0, idx, 3'd0};
        end
    endfunction

endpackage

@@ hw/rtl/fptw_req_if.sv @@
// fptw_req_if: input item channel of the walker (start or memory response)
// depends on fptw_pkg

interface fptw_req_if import fptw_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    t_addr virt_addr;
    t_addr table_root_virt;
    t_addr read_data;
    logic  read_ok;

    modport source (output valid, cmd, virt_addr, table_root_virt, read_data, read_ok,
                    input ready);
    modport sink   (input valid, cmd, virt_addr, table_root_virt, read_data, read_ok,
                    output ready);
endinterface

@@ hw/rtl/fptw_rsp_if.sv @@
// fptw_rsp_if: result item channel of the walker (read request, done, fault)
// depends on fptw_pkg

interface fptw_rsp_if import fptw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind result_kind;
    t_addr result_addr;

    modport source (output valid, result_kind, result_addr, input ready);
    modport sink   (input valid, result_kind, result_addr, output ready);
endinterface

@@ hw/rtl/four_level_page_table_walker_core.sv @@
// four_level_page_table_walker_core: x86-64 style 4-level walk; one item per ready cycle
// an accepted result is registered in the output register, or in skid if o_rsp stalls
// throughput: one item per cycle while skid is empty; a one-entry skid stage behind
// the output register keeps i_req ready while a single result waits on o_rsp
// reset (synchronous, i_rst_n low): walker idle, output and skid empty, registers at defaults
// depends on fptw_pkg, fptw_req_if, fptw_rsp_if

module four_level_page_table_walker_core import fptw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fptw_req_if.sink           i_req,
    fptw_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [ADDR_W-1:0]  pwdata,
    output logic [ADDR_W-1:0]  prdata,
    output logic               pready
);

    t_addr  r_kimg_base;
    t_addr  r_dmap_base;
    t_level r_level, n_level;
    t_vaddr r_vaddr, n_vaddr;

    logic   r_out_valid, n_out_valid;
    t_kind  r_out_kind, n_out_kind;
    t_addr  r_out_addr, n_out_addr;
    logic   r_skid_valid, n_skid_valid;
    t_kind  r_skid_kind, n_skid_kind;
    t_addr  r_skid_addr, n_skid_addr;

    logic   in_fire, out_fire, cfg_wr;
    logic   res_valid;
    t_kind  res_kind;
    t_addr  res_addr;
    t_addr  root_phys;
    t_level lvl_dn;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = paddr[3] ? r_dmap_base : r_kimg_base;

    assign i_req.ready = !r_skid_valid;
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_fire    = r_out_valid && o_rsp.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.result_addr = r_out_addr;

    // kernel image window: top 33 bits all ones
    always_comb begin
        if (&i_req.table_root_virt[ADDR_W-1:WIN_LO_W]) begin
            root_phys = {{(ADDR_W-WIN_LO_W){1'b0}}, i_req.table_root_virt[WIN_LO_W-1:0]}
                        + r_kimg_base;
        end else begin
            root_phys = i_req.table_root_virt - r_dmap_base;
        end
    end

    assign lvl_dn = r_level - 3'd1;

    always_comb begin
        n_level   = r_level;
        n_vaddr   = r_vaddr;
        res_valid = 1'b0;
        res_kind  = KIND_READ;
        res_addr  = '0;
        if (in_fire) begin
            if (i_req.cmd == CMD_START) begin
                n_vaddr   = i_req.virt_addr[VADDR_W-1:0];
                n_level   = LVL_PML4;
                res_valid = 1'b1;
                res_kind  = KIND_READ;
                res_addr  = root_phys
                            + index_bytes(i_req.virt_addr[VADDR_W-1:0], LVL_PML4);
            end else if (r_level >= LVL_PT && r_level <= LVL_PML4) begin
                res_valid = 1'b1;
                if (!i_req.read_ok) begin
                    n_level  = LVL_IDLE;
                    res_kind = KIND_FAULT;
                    res_addr = '0;
                end else if (r_level == LVL_PT) begin
                    n_level  = LVL_IDLE;
                    res_kind = KIND_DONE;
                    res_addr = (i_req.read_data & ENTRY_FRAME_MASK)
                               | {{(ADDR_W-OFF_W){1'b0}}, r_vaddr[OFF_W-1:0]};
                end else begin
                    n_level  = lvl_dn;
                    res_kind = KIND_READ;
                    res_addr = (i_req.read_data & ENTRY_FRAME_MASK)
                               + index_bytes(r_vaddr, lvl_dn);
                end
            end
        end
    end

    // output register with one skid entry; skid only fills while the output is held
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_addr   = r_out_addr;
        n_skid_valid = r_skid_valid;
        n_skid_kind  = r_skid_kind;
        n_skid_addr  = r_skid_addr;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_kind   = r_skid_kind;
                n_out_addr   = r_skid_addr;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out_kind  = res_kind;
                n_out_addr  = res_addr;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_kind  = res_kind;
            n_skid_addr  = res_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kimg_base  <= KIMG_PHYS_RST;
            r_dmap_base  <= DMAP_VIRT_RST;
            r_level      <= LVL_IDLE;
            r_vaddr      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[3]) begin
                    r_dmap_base <= pwdata;
                end else begin
                    r_kimg_base <= pwdata;
                end
            end
            r_level      <= n_level;
            r_vaddr      <= n_vaddr;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_addr  <= n_out_addr;
        r_skid_kind <= n_skid_kind;
        r_skid_addr <= n_skid_addr;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_PML4)
        else $error("walk level out of range");

    a_start_to_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.cmd == CMD_START) |=> (r_level == LVL_PML4))
        else $error("start item did not enter top level");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_FAULT) |-> (r_out_addr == '0))
        else $error("fault result carries nonzero address");

    a_idle_resp_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.cmd == CMD_RESP && r_level == LVL_IDLE && r_out_valid
         && !o_rsp.ready) |=> !r_skid_valid)
        else $error("response while idle produced a result");

endmodule
